[hdl/sle_pkg.sv]
// Shared types, constants and key tables for the scancode line editor.
package sle_pkg;

    localparam int LINE_DEPTH  = 64;
    localparam int LINE_AW     = $clog2(LINE_DEPTH);
    localparam int CHAR_W      = 7;
    localparam int LIMIT_W     = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 7'd64;
    localparam logic [LIMIT_W-1:0] LIMIT_CEILING = 7'(LINE_DEPTH);

    // Scan codes, set 1
    localparam logic [7:0] SC_EXT_PREFIX  = 8'hE0;
    localparam logic [7:0] SC_ARROW_LEFT  = 8'h4B;
    localparam logic [7:0] SC_ARROW_RIGHT = 8'h4D;
    localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
    localparam logic [7:0] SC_CAPS_LOCK   = 8'h3A;
    localparam logic [7:0] SC_KEY_COUNT   = 8'd58;

    localparam logic [CHAR_W-1:0] ASCII_NUL = 7'd0;
    localparam logic [CHAR_W-1:0] ASCII_BS  = 7'd8;
    localparam logic [CHAR_W-1:0] ASCII_LF  = 7'd10;
    localparam logic [CHAR_W-1:0] ASCII_LC_A = 7'h61;
    localparam logic [CHAR_W-1:0] ASCII_LC_Z = 7'h7A;
    localparam logic [CHAR_W-1:0] ASCII_CASE = 7'd32;

    // Result kinds
    localparam logic [2:0] EVT_INSERT = 3'd0;
    localparam logic [2:0] EVT_DELETE = 3'd1;
    localparam logic [2:0] EVT_MOVE   = 3'd2;
    localparam logic [2:0] EVT_CHAR   = 3'd3;
    localparam logic [2:0] EVT_END    = 3'd4;

    typedef enum logic [2:0] {
        CMD_INSERT,
        CMD_DELETE,
        CMD_LEFT,
        CMD_RIGHT,
        CMD_ENTER
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CHAR_W-1:0] ch;
    } cmd_t;

    function automatic logic [CHAR_W-1:0] key_lookup(input logic [5:0] code);
        logic [CHAR_W-1:0] c;
        case (code)
            6'd1:  c = 7'd27;
            6'd2:  c = 7'h31;
            6'd3:  c = 7'h32;
            6'd4:  c = 7'h33;
            6'd5:  c = 7'h34;
            6'd6:  c = 7'h35;
            6'd7:  c = 7'h36;
            6'd8:  c = 7'h37;
            6'd9:  c = 7'h38;
            6'd10: c = 7'h39;
            6'd11: c = 7'h30;
            6'd12: c = 7'h2D;
            6'd13: c = 7'h3D;
            6'd14: c = 7'd8;
            6'd15: c = 7'd9;
            6'd16: c = 7'h71;
            6'd17: c = 7'h77;
            6'd18: c = 7'h65;
            6'd19: c = 7'h72;
            6'd20: c = 7'h74;
            6'd21: c = 7'h79;
            6'd22: c = 7'h75;
            6'd23: c = 7'h69;
            6'd24: c = 7'h6F;
            6'd25: c = 7'h70;
            6'd26: c = 7'h5B;
            6'd27: c = 7'h5D;
            6'd28: c = 7'd10;
            6'd30: c = 7'h61;
            6'd31: c = 7'h73;
            6'd32: c = 7'h64;
            6'd33: c = 7'h66;
            6'd34: c = 7'h67;
            6'd35: c = 7'h68;
            6'd36: c = 7'h6A;
            6'd37: c = 7'h6B;
            6'd38: c = 7'h6C;
            6'd39: c = 7'h3B;
            6'd40: c = 7'h27;
            6'd41: c = 7'h60;
            6'd43: c = 7'h5C;
            6'd44: c = 7'h7A;
            6'd45: c = 7'h78;
            6'd46: c = 7'h63;
            6'd47: c = 7'h76;
            6'd48: c = 7'h62;
            6'd49: c = 7'h6E;
            6'd50: c = 7'h6D;
            6'd51: c = 7'h2C;
            6'd52: c = 7'h2E;
            6'd53: c = 7'h2F;
            6'd55: c = 7'h2A;
            6'd57: c = 7'h20;
            default: c = ASCII_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] shifted_symbol(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] s;
        case (c)
            7'h31: s = 7'h21;
            7'h32: s = 7'h40;
            7'h33: s = 7'h23;
            7'h34: s = 7'h24;
            7'h35: s = 7'h25;
            7'h36: s = 7'h5E;
            7'h37: s = 7'h26;
            7'h38: s = 7'h2A;
            7'h39: s = 7'h28;
            7'h30: s = 7'h29;
            7'h2D: s = 7'h5F;
            7'h3D: s = 7'h2B;
            7'h5B: s = 7'h7B;
            7'h5D: s = 7'h7D;
            7'h3B: s = 7'h3A;
            7'h27: s = 7'h22;
            7'h2C: s = 7'h3C;
            7'h2E: s = 7'h3E;
            7'h2F: s = 7'h3F;
            7'h5C: s = 7'h7C;
            7'h60: s = 7'h7E;
            default: s = c;
        endcase
        return s;
    endfunction

endpackage

[hdl/scancode_line_editor.sv]
// Top level of the scancode line editor: front end, command queue, line engine.
//
// Takes one set-1 scan code byte per input transaction and keeps an editable
// text line of up to line_limit-1 characters (at most 63). The front end
// tracks shift, caps lock and the extended prefix and accepts one byte per
// cycle while the four-entry command queue has room; bytes that only touch
// modifier flags, release codes and unmapped keys produce no result. The line
// engine works one command at a time against a single-port-write,
// registered-read line RAM, so its cost is set by that RAM port: arrow keys
// and dropped commands are done in the idle state, an insert or a backspace
// moves every character behind the point one slot through that port, and
// Enter streams the line out at one result per cycle while out_stall is low,
// ending with a line-end result. Each result sits in an output register; the
// engine takes the next command from the queue only once that register is
// empty or being read, so a result that waits on out_stall holds the engine
// while the front end keeps filling the queue. The line RAM needs no clearing
// after reset: only characters below the held length are ever read. Write
// line_limit only while the block is idle; it takes effect on the next insert.
module scancode_line_editor (
    input  logic                         clk,
    input  logic                         rst_n,
    // scan byte channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   scan_byte,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sle_pkg::LIMIT_W-1:0]  line_limit,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   event_kind,
    output logic [sle_pkg::CHAR_W-1:0]   char_code,
    output logic [sle_pkg::LINE_AW-1:0]  edit_point,
    output logic [sle_pkg::LINE_AW-1:0]  line_length,
    output logic                         last_of_run
);
    import sle_pkg::*;

    logic [LIMIT_W-1:0] line_limit_reg;
    logic               q_push;
    cmd_t               q_push_cmd;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;
    cmd_t               q_head;

    // Always take configuration writes; hold the limit until the next one.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            line_limit_reg <= line_limit;
        end
    end

    // Classify scan bytes into editing commands.
    sle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .scan_byte (scan_byte),
        .q_full    (q_full),
        .push      (q_push),
        .push_cmd  (q_push_cmd)
    );

    // Decouple the front end from the line engine.
    sle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    // Carry out commands on the line and drive results.
    sle_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .line_limit_cfg (line_limit_reg),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .char_code      (char_code),
        .edit_point     (edit_point),
        .line_length    (line_length),
        .last_of_run    (last_of_run)
    );

endmodule

[hdl/sle_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/sle_front.sv]
// Front end: accept scan bytes, track modifier flags, classify into commands.
module sle_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    scan_byte,
    input  logic          q_full,
    output logic          push,
    output sle_pkg::cmd_t push_cmd
);
    import sle_pkg::*;

    logic              shift_reg, shift_next;
    logic              caps_reg, caps_next;
    logic              ext_reg, ext_next;
    logic              accept;
    logic [CHAR_W-1:0] base_char;
    logic [CHAR_W-1:0] char_mod;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        base_char = key_lookup(scan_byte[5:0]);
        if (base_char >= ASCII_LC_A && base_char <= ASCII_LC_Z)
        begin
            char_mod = (shift_reg != caps_reg) ? base_char - ASCII_CASE : base_char;
        end
        else if (shift_reg)
        begin
            char_mod = shifted_symbol(base_char);
        end
        else
        begin
            char_mod = base_char;
        end
    end

    always_comb
    begin
        shift_next    = shift_reg;
        caps_next     = caps_reg;
        ext_next      = ext_reg;
        push          = 1'b0;
        push_cmd.kind = CMD_INSERT;
        push_cmd.ch   = char_mod;
        if (accept)
        begin
            if (ext_reg)
            begin
                ext_next = 1'b0;
                if (scan_byte == SC_ARROW_LEFT)
                begin
                    push          = 1'b1;
                    push_cmd.kind = CMD_LEFT;
                end
                else if (scan_byte == SC_ARROW_RIGHT)
                begin
                    push          = 1'b1;
                    push_cmd.kind = CMD_RIGHT;
                end
            end
            else if (scan_byte == SC_EXT_PREFIX)
            begin
                ext_next = 1'b1;
            end
            else if (scan_byte == SC_LSHIFT_MAKE || scan_byte == SC_RSHIFT_MAKE)
            begin
                shift_next = 1'b1;
            end
            else if (scan_byte == SC_LSHIFT_BRK || scan_byte == SC_RSHIFT_BRK)
            begin
                shift_next = 1'b0;
            end
            else if (scan_byte == SC_CAPS_LOCK)
            begin
                caps_next = !caps_reg;
            end
            else if (scan_byte < SC_KEY_COUNT && base_char != ASCII_NUL)
            begin
                // release codes all sit above the key table
                push = 1'b1;
                if (char_mod == ASCII_LF)
                begin
                    push_cmd.kind = CMD_ENTER;
                end
                else if (char_mod == ASCII_BS)
                begin
                    push_cmd.kind = CMD_DELETE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            caps_reg  <= 1'b0;
            ext_reg   <= 1'b0;
        end
        else
        begin
            shift_reg <= shift_next;
            caps_reg  <= caps_next;
            ext_reg   <= ext_next;
        end
    end

endmodule

[hdl/sle_queue.sv]
// Short command queue between the front end and the line engine.
module sle_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sle_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output sle_pkg::cmd_t head
);
    import sle_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/sle_back.sv]
// Line engine: carry out commands on the line buffer and drive results.
module sle_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [sle_pkg::LIMIT_W-1:0]  line_limit_cfg,
    input  logic                         q_empty,
    input  sle_pkg::cmd_t                q_head,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   event_kind,
    output logic [sle_pkg::CHAR_W-1:0]   char_code,
    output logic [sle_pkg::LINE_AW-1:0]  edit_point,
    output logic [sle_pkg::LINE_AW-1:0]  line_length,
    output logic                         last_of_run
);
    import sle_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_INS  = 5'b00010,
        ST_DEL  = 5'b00100,
        ST_READ = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [LINE_AW-1:0]  held_reg, held_next;
    logic [LINE_AW-1:0]  point_reg, point_next;
    logic [LINE_AW-1:0]  idx_reg, idx_next;
    logic [LINE_AW-1:0]  emit_idx_reg, emit_idx_next;
    logic [LINE_AW-1:0]  wr_addr_reg, wr_addr_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [2:0]          res_kind_reg, res_kind_next;
    logic [CHAR_W-1:0]   res_char_reg, res_char_next;

    logic                out_valid_reg;
    logic [2:0]          out_kind_reg, out_kind_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;
    logic [LINE_AW-1:0]  out_point_reg, out_point_next;
    logic [LINE_AW-1:0]  out_len_reg, out_len_next;
    logic                out_last_reg, out_last_next;
    logic                out_load;
    logic                load_ok;

    logic                ram_we;
    logic [LINE_AW-1:0]  ram_waddr;
    logic [CHAR_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [LINE_AW-1:0]  ram_raddr;
    logic [CHAR_W-1:0]   ram_rdata;

    logic [LIMIT_W-1:0]  lim_clip;
    logic [LIMIT_W-1:0]  capacity;

    sle_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign load_ok = !out_valid_reg || !out_stall;

    always_comb
    begin
        lim_clip = (line_limit_cfg > LIMIT_CEILING) ? LIMIT_CEILING : line_limit_cfg;
        capacity = (lim_clip < 7'd2) ? '0 : lim_clip - 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        point_next     = point_reg;
        idx_next       = idx_reg;
        emit_idx_next  = emit_idx_reg;
        wr_addr_next   = wr_addr_reg;
        rd_pend_next   = rd_pend_reg;
        res_kind_next  = res_kind_reg;
        res_char_next  = res_char_reg;
        q_pop          = 1'b0;
        out_load       = 1'b0;
        out_kind_next  = out_kind_reg;
        out_char_next  = out_char_reg;
        out_point_next = out_point_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = wr_addr_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && load_ok)
                begin
                    q_pop        = 1'b1;
                    rd_pend_next = 1'b0;
                    case (q_head.kind)
                        CMD_LEFT:
                        begin
                            if (point_reg != '0)
                            begin
                                point_next     = point_reg - 1'b1;
                                out_load       = 1'b1;
                                out_kind_next  = EVT_MOVE;
                                out_char_next  = ASCII_NUL;
                                out_point_next = point_reg - 1'b1;
                                out_len_next   = held_reg;
                                out_last_next  = 1'b1;
                            end
                        end
                        CMD_RIGHT:
                        begin
                            if (point_reg < held_reg)
                            begin
                                point_next     = point_reg + 1'b1;
                                out_load       = 1'b1;
                                out_kind_next  = EVT_MOVE;
                                out_char_next  = ASCII_NUL;
                                out_point_next = point_reg + 1'b1;
                                out_len_next   = held_reg;
                                out_last_next  = 1'b1;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (point_reg != '0)
                            begin
                                idx_next   = point_reg;
                                state_next = ST_DEL;
                            end
                        end
                        CMD_INSERT:
                        begin
                            if ({1'b0, held_reg} < capacity)
                            begin
                                idx_next      = held_reg;
                                res_char_next = q_head.ch;
                                state_next    = ST_INS;
                            end
                        end
                        CMD_ENTER:
                        begin
                            idx_next   = '0;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Move the tail up one slot, top down, then drop the new char in.
            ST_INS:
            begin
                if (rd_pend_reg)
                begin
                    ram_we = 1'b1;
                end
                if (idx_reg > point_reg)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = idx_reg - 1'b1;
                    wr_addr_next = idx_reg;
                    idx_next     = idx_reg - 1'b1;
                    rd_pend_next = 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    ram_we        = 1'b1;
                    ram_waddr     = point_reg;
                    ram_wdata     = res_char_reg;
                    held_next     = held_reg + 1'b1;
                    point_next    = point_reg + 1'b1;
                    res_kind_next = EVT_INSERT;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end
            end

            // Move the tail down one slot, bottom up.
            ST_DEL:
            begin
                if (rd_pend_reg)
                begin
                    ram_we = 1'b1;
                end
                if (idx_reg < held_reg)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = idx_reg;
                    wr_addr_next = idx_reg - 1'b1;
                    idx_next     = idx_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    held_next     = held_reg - 1'b1;
                    point_next    = point_reg - 1'b1;
                    res_kind_next = EVT_DELETE;
                    res_char_next = ASCII_NUL;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end
            end

            // Stream the line out; read data holds in the RAM while stalled.
            ST_READ:
            begin
                if (rd_pend_reg && load_ok)
                begin
                    out_load       = 1'b1;
                    out_kind_next  = EVT_CHAR;
                    out_char_next  = ram_rdata;
                    out_point_next = emit_idx_reg;
                    out_len_next   = held_reg;
                    out_last_next  = 1'b0;
                    rd_pend_next   = 1'b0;
                end
                if (idx_reg < held_reg && (!rd_pend_reg || load_ok))
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = idx_reg;
                    emit_idx_next = idx_reg;
                    idx_next      = idx_reg + 1'b1;
                    rd_pend_next  = 1'b1;
                end
                else if (idx_reg == held_reg && !rd_pend_reg && load_ok)
                begin
                    out_load       = 1'b1;
                    out_kind_next  = EVT_END;
                    out_char_next  = ASCII_NUL;
                    out_point_next = '0;
                    out_len_next   = '0;
                    out_last_next  = 1'b1;
                    held_next      = '0;
                    point_next     = '0;
                    state_next     = ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                if (load_ok)
                begin
                    out_load       = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_char_next  = res_char_reg;
                    out_point_next = point_reg;
                    out_len_next   = held_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            point_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            point_reg   <= point_next;
            rd_pend_reg <= rd_pend_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        emit_idx_reg  <= emit_idx_next;
        wr_addr_reg   <= wr_addr_next;
        res_kind_reg  <= res_kind_next;
        res_char_reg  <= res_char_next;
        out_kind_reg  <= out_kind_next;
        out_char_reg  <= out_char_next;
        out_point_reg <= out_point_next;
        out_len_reg   <= out_len_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign event_kind  = out_kind_reg;
    assign char_code   = out_char_reg;
    assign edit_point  = out_point_reg;
    assign line_length = out_len_reg;
    assign last_of_run = out_last_reg;

endmodule
